// ----- sv/ptdc_pkg.sv -----
// ----------------------------------------------------------------------------
// PWM tone divider calculator package
// Shared widths, constants and the command and status types between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ptdc_pkg;

    localparam int unsigned CLK_W    = 28;
    localparam int unsigned TONE_W   = 20;
    localparam int unsigned DIV_W    = 12;
    localparam int unsigned PERIOD_W = 16;
    localparam int unsigned QUOT_W   = 32;

    localparam int unsigned FRAC_SCALE    = 16;
    localparam int unsigned DIV_INT_LIMIT = 256;
    localparam int unsigned PERIOD_LIMIT  = 65534;

    localparam logic [CLK_W-1:0] CLK_HZ_RESET = CLK_W'(125000000);

    // Exact reciprocals for unsigned 32-bit division by 5 and by 3.
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul5;
        logic mul3;
        logic fact_step;
        logic write_out;
    } cmd_t;

    typedef struct packed {
        logic tone_zero;
        logic step_apply;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ----- sv/ptdc_datapath.sv -----
// ----------------------------------------------------------------------------
// PWM tone divider calculator datapath
// Holds the clock register, the bit-serial divider, the shared reciprocal
// multiplier, the factor step logic and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdc_datapath (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_wr_en,
    input  wire  [ptdc_pkg::CLK_W-1:0]        cfg_wr_data,
    input  wire  [ptdc_pkg::TONE_W-1:0]       tone_hz,
    input  wire                               out_ready,
    input  wire  ptdc_pkg::cmd_t              cmd,
    output ptdc_pkg::status_t                 status,
    output logic                              out_valid,
    output logic                              settings_valid,
    output logic [ptdc_pkg::DIV_W-1:0]        clock_divider,
    output logic [ptdc_pkg::PERIOD_W-1:0]     period_top
);

    localparam int unsigned TW = ptdc_pkg::TONE_W;
    localparam int unsigned QW = ptdc_pkg::QUOT_W;
    localparam int unsigned PW = ptdc_pkg::PERIOD_W;

    localparam logic [PW-1:0] PMAX5 = PW'(ptdc_pkg::PERIOD_LIMIT / 5);
    localparam logic [PW-1:0] PMAX3 = PW'(ptdc_pkg::PERIOD_LIMIT / 3);
    localparam logic [PW-1:0] PMAX2 = PW'(ptdc_pkg::PERIOD_LIMIT / 2);
    localparam logic [QW-1:0] DMIN5 = QW'(ptdc_pkg::FRAC_SCALE * 5);
    localparam logic [QW-1:0] DMIN3 = QW'(ptdc_pkg::FRAC_SCALE * 3);
    localparam logic [QW-1:0] DMIN2 = QW'(ptdc_pkg::FRAC_SCALE * 2);
    localparam logic [QW-1:0] DLOW  = QW'(ptdc_pkg::FRAC_SCALE);
    localparam logic [QW-1:0] DHIGH = QW'(ptdc_pkg::DIV_INT_LIMIT * ptdc_pkg::FRAC_SCALE);

    logic [ptdc_pkg::CLK_W-1:0] clk_hz_reg;
    logic [TW-1:0]              tone_reg,   tone_next;
    logic [QW-1:0]              dq_reg,     dq_next;
    logic [TW-1:0]              rem_reg,    rem_next;
    logic [PW-1:0]              period_reg, period_next;
    logic [QW-3:0]              q5_reg;
    logic [QW-2:0]              q3_reg;
    logic                       out_valid_reg, out_valid_next;
    logic                       res_valid_reg;
    logic [ptdc_pkg::DIV_W-1:0] res_div_reg;
    logic [PW-1:0]              res_period_reg;

    logic [TW:0]     trial;
    logic [TW:0]     diff;
    logic            ge;
    logic [31:0]     mul_const;
    logic [63:0]     prod;
    logic [QW:0]     back5;
    logic [QW:0]     back3;
    logic            take5, take3, take2;
    logic [PW+2:0]   period_x5;
    logic [PW+1:0]   period_x3;
    logic            in_range;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, dq_reg[QW-1]};
    assign diff  = trial - {1'b0, tone_reg};
    assign ge    = (trial >= {1'b0, tone_reg});

    assign mul_const = cmd.mul5 ? ptdc_pkg::RECIP5 : ptdc_pkg::RECIP3;
    assign prod      = {32'b0, dq_reg} * {32'b0, mul_const};

    // The quotient times the factor equals the dividend only when it divides evenly.
    assign back5 = {1'b0, q5_reg, 2'b00} + {3'b000, q5_reg};
    assign back3 = {1'b0, q3_reg, 1'b0} + {2'b00, q3_reg};

    assign take5 = (dq_reg >= DMIN5) && (back5 == {1'b0, dq_reg}) && (period_reg <= PMAX5);
    assign take3 = !take5 && (dq_reg >= DMIN3) && (back3 == {1'b0, dq_reg})
                   && (period_reg <= PMAX3);
    assign take2 = !take5 && !take3 && (dq_reg >= DMIN2) && (period_reg <= PMAX2);

    assign period_x5 = {1'b0, period_reg, 2'b00} + {3'b000, period_reg};
    assign period_x3 = {1'b0, period_reg, 1'b0} + {2'b00, period_reg};

    assign in_range = (dq_reg >= DLOW) && (dq_reg < DHIGH);

    assign status.tone_zero  = (tone_hz == '0);
    assign status.step_apply = take5 || take3 || take2;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        tone_next   = tone_reg;
        dq_next     = dq_reg;
        rem_next    = rem_reg;
        period_next = period_reg;
        if (cmd.load)
        begin
            tone_next   = tone_hz;
            dq_next     = status.tone_zero ? '0 : {clk_hz_reg, 4'b0000};
            rem_next    = '0;
            period_next = PW'(1);
        end
        else if (cmd.div_step)
        begin
            dq_next  = {dq_reg[QW-2:0], ge};
            rem_next = ge ? diff[TW-1:0] : trial[TW-1:0];
        end
        else if (cmd.fact_step)
        begin
            priority if (take5)
            begin
                dq_next     = {2'b00, q5_reg};
                period_next = period_x5[PW-1:0];
            end
            else if (take3)
            begin
                dq_next     = {1'b0, q3_reg};
                period_next = period_x3[PW-1:0];
            end
            else if (take2)
            begin
                dq_next     = {1'b0, dq_reg[QW-1:1]};
                period_next = {period_reg[PW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.write_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg    <= ptdc_pkg::CLK_HZ_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                clk_hz_reg <= cfg_wr_data;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tone_reg   <= tone_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        period_reg <= period_next;
        if (cmd.mul5)
            q5_reg <= prod[63:34];
        if (cmd.mul3)
            q3_reg <= prod[63:33];
        if (cmd.write_out)
        begin
            res_valid_reg  <= in_range;
            res_div_reg    <= in_range ? dq_reg[ptdc_pkg::DIV_W-1:0] : '0;
            res_period_reg <= in_range ? period_reg : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign settings_valid = res_valid_reg;
    assign clock_divider  = res_div_reg;
    assign period_top     = res_period_reg;

endmodule

`default_nettype wire

// ----- sv/ptdc_ctrl.sv -----
// ----------------------------------------------------------------------------
// PWM tone divider calculator controller
// Sequences the division, the factor rounds and the write of the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptdc_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  ptdc_pkg::status_t status,
    output ptdc_pkg::cmd_t      cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL5 = 3'd2;
    localparam logic [2:0] S_MUL3 = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam int unsigned CNT_W = $clog2(ptdc_pkg::QUOT_W);

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.tone_zero ? S_FIN : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ptdc_pkg::QUOT_W - 1))
                    state_next = S_MUL5;
            end
            S_MUL5:
            begin
                cmd.mul5   = 1'b1;
                state_next = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.mul3   = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.fact_step = 1'b1;
                state_next    = status.step_apply ? S_MUL5 : S_FIN;
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pwm_tone_divider_calculator.sv -----
// ----------------------------------------------------------------------------
// PWM tone divider calculator
// Turns a tone frequency into a PWM clock divider and counter wrap value.
// ----------------------------------------------------------------------------
// Each request computes 16 * system_clock_hz / tone_hz with a bit-serial
// divider, then moves factors of 5, 3 and 2 into the period, one factor per
// round of the MUL5, MUL3 and STEP states on a shared reciprocal multiplier.
// Up to fifteen rounds move a factor and one more finds nothing left to move.
// The time from acceptance to a valid result depends on the number of factor
// rounds and on the output being free; a zero tone skips the division and the
// factor rounds. A new request is taken as soon as the previous result has
// been written to the output register, even while that result still waits.
// Write the clock register only while the block is idle.
`default_nettype none

module pwm_tone_divider_calculator (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_wr_en,
    input  wire  [ptdc_pkg::CLK_W-1:0]    cfg_wr_data,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [ptdc_pkg::TONE_W-1:0]   tone_hz,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic                          settings_valid,
    output logic [ptdc_pkg::DIV_W-1:0]    clock_divider,
    output logic [ptdc_pkg::PERIOD_W-1:0] period_top
);

    ptdc_pkg::cmd_t    cmd;
    ptdc_pkg::status_t status;

    ptdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    ptdc_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .tone_hz        (tone_hz),
        .out_ready      (out_ready),
        .cmd            (cmd),
        .status         (status),
        .out_valid      (out_valid),
        .settings_valid (settings_valid),
        .clock_divider  (clock_divider),
        .period_top     (period_top)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while the previous one is in progress");

    a_valid_divider: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && settings_valid) |-> (clock_divider[11:4] != 8'd0))
        else $error("valid result with divider integer part zero");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !settings_valid) |-> (clock_divider == '0 && period_top == '0))
        else $error("invalid result carries nonzero settings");

    a_period_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (period_top <= 16'(ptdc_pkg::PERIOD_LIMIT)))
        else $error("period exceeds limit");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// PWM tone divider calculator testbench
// Sends tone requests through the valid/ready input and predicts the divider
// and period for each one under the current clock setting. Every result is
// checked in order against those predictions. Clock settings, sender idling
// and receiver stalls change from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned CLK_W         = ptdc_pkg::CLK_W;
    localparam int unsigned TONE_W        = ptdc_pkg::TONE_W;
    localparam int unsigned DIV_W         = ptdc_pkg::DIV_W;
    localparam int unsigned PERIOD_W      = ptdc_pkg::PERIOD_W;
    localparam int unsigned FRAC_SCALE    = ptdc_pkg::FRAC_SCALE;
    localparam int unsigned DIV_INT_LIMIT = ptdc_pkg::DIV_INT_LIMIT;
    localparam int unsigned PERIOD_LIMIT  = ptdc_pkg::PERIOD_LIMIT;

    localparam logic [CLK_W-1:0]  CLK_HZ_RESET = ptdc_pkg::CLK_HZ_RESET;
    localparam logic [CLK_W-1:0]  CLK_HZ_MAX  = {CLK_W{1'b1}};
    localparam logic [TONE_W-1:0] TONE_MAX    = {TONE_W{1'b1}};
    localparam int                DRAIN_WAIT  = 100;
    localparam int                PRINT_LIMIT = 30;

    typedef struct packed {
        logic [TONE_W-1:0]   tone;
        logic                settings_ok;
        logic [DIV_W-1:0]    divider;
        logic [PERIOD_W-1:0] top;
    } pwm_setting_t;

    class tone_scoreboard;
        pwm_setting_t pending_settings[$];
        int           mismatches;
        int           results_checked;
        int           valid_results;

        function pwm_setting_t compute_pwm_setting(logic [TONE_W-1:0] tone,
                                                   logic [CLK_W-1:0] clk_hz);
            logic [31:0]  d;
            logic [31:0]  period;
            bit           moving;
            pwm_setting_t s;
            s      = '0;
            s.tone = tone;
            if (tone == '0)
                return s;
            d      = (32'(clk_hz) * FRAC_SCALE) / 32'(tone);
            period = 1;
            moving = 1'b1;
            // Factors of 5 and 3 only move when they divide evenly; 2 may move when it does not.
            while (moving)
            begin
                if (d >= FRAC_SCALE * 5 && d % 5 == 0 && period * 5 <= PERIOD_LIMIT)
                begin
                    d      = d / 5;
                    period = period * 5;
                end
                else if (d >= FRAC_SCALE * 3 && d % 3 == 0 && period * 3 <= PERIOD_LIMIT)
                begin
                    d      = d / 3;
                    period = period * 3;
                end
                else if (d >= FRAC_SCALE * 2 && period * 2 <= PERIOD_LIMIT)
                begin
                    d      = d / 2;
                    period = period * 2;
                end
                else
                    moving = 1'b0;
            end
            if (d >= FRAC_SCALE && d < DIV_INT_LIMIT * FRAC_SCALE)
            begin
                s.settings_ok = 1'b1;
                s.divider     = d[DIV_W-1:0];
                s.top         = period[PERIOD_W-1:0];
            end
            return s;
        endfunction

        function void note_request(logic [TONE_W-1:0] tone, logic [CLK_W-1:0] clk_hz);
            pending_settings.push_back(compute_pwm_setting(tone, clk_hz));
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("[%0t] MISMATCH %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic ok, logic [DIV_W-1:0] div, logic [PERIOD_W-1:0] top);
            pwm_setting_t exp_s;
            results_checked++;
            if (ok === 1'b1)
                valid_results++;
            if (pending_settings.size() == 0)
            begin
                report($sformatf("result valid=%0b div=%0d top=%0d with no request pending",
                                 ok, div, top));
                return;
            end
            exp_s = pending_settings.pop_front();
            if (ok !== exp_s.settings_ok)
                report($sformatf("tone %0d: settings_valid %0b, expected %0b",
                                 exp_s.tone, ok, exp_s.settings_ok));
            if (div !== exp_s.divider)
                report($sformatf("tone %0d: clock_divider %0d, expected %0d",
                                 exp_s.tone, div, exp_s.divider));
            if (top !== exp_s.top)
                report($sformatf("tone %0d: period_top %0d, expected %0d",
                                 exp_s.tone, top, exp_s.top));
        endtask
    endclass

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CLK_W-1:0]    cfg_wr_data = '0;
    logic                in_valid    = 1'b0;
    logic [TONE_W-1:0]   tone_hz     = '0;
    logic                out_ready   = 1'b0;
    logic                in_ready;
    logic                out_valid;
    logic                settings_valid;
    logic [DIV_W-1:0]    clock_divider;
    logic [PERIOD_W-1:0] period_top;

    tone_scoreboard      sb;
    logic [CLK_W-1:0]    clock_setting      = CLK_HZ_RESET;
    int                  sender_idle_pct    = 0;
    int                  receiver_stall_pct = 0;
    int                  clock_writes       = 0;
    int                  requests_sent      = 0;

    pwm_tone_divider_calculator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tone_hz        (tone_hz),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .settings_valid (settings_valid),
        .clock_divider  (clock_divider),
        .period_top     (period_top)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Results are sampled with their pre-edge values; ready is redrawn each cycle.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(settings_valid, clock_divider, period_top);
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic send_tone(logic [TONE_W-1:0] tone);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        tone_hz  <= tone;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(tone, clock_setting);
        requests_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (sb.pending_settings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_clock(logic [CLK_W-1:0] clk_hz);
        wait_for_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= clk_hz;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        clock_setting  = clk_hz;
        clock_writes++;
    endtask

    function automatic logic [TONE_W-1:0] random_tone(logic [CLK_W-1:0] clk_hz);
        longint t;
        case ($urandom_range(9))
            0, 1, 2, 3: t = longint'($urandom_range(TONE_MAX));
            4, 5:       t = longint'($urandom_range(20000, 20));
            6:          t = longint'($urandom_range(15));
            7:
            begin
                // Tones around the clock itself sit on the divider's lower bound.
                if (clk_hz <= TONE_MAX + 8)
                    t = longint'(clk_hz) + longint'($urandom_range(16)) - 8;
                else
                    t = longint'($urandom_range(TONE_MAX));
            end
            8:          t = (longint'(1) << $urandom_range(TONE_W - 1))
                            - longint'($urandom_range(1));
            default:    t = longint'(clk_hz) / longint'($urandom_range(8192, 1));
        endcase
        if (t < 0)
            t = 0;
        if (t > TONE_MAX)
            t = TONE_MAX;
        return t[TONE_W-1:0];
    endfunction

    task automatic run_phase(logic [CLK_W-1:0] clk_hz, int idle_pct, int stall_pct,
                             int count, bit pause_midway);
        write_clock(clk_hz);
        for (int i = 0; i < count; i++)
        begin
            // Every so often a stretch runs with neither side holding back.
            if (i % 50 >= 40)
            begin
                sender_idle_pct    = 0;
                receiver_stall_pct <= 0;
            end
            else
            begin
                sender_idle_pct    = idle_pct;
                receiver_stall_pct <= stall_pct;
            end
            if (pause_midway && i == count / 2)
                wait_for_results();
            send_tone(random_tone(clk_hz));
        end
    endtask

    initial
    begin
        int unsigned directed[$];
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests under the clock setting left by reset.
        directed = '{0, 1, 2, 3, 5, 7, 15, 16, 440, 1000, 32768, 44100, 65535, 65536,
                     999983, TONE_MAX};
        foreach (directed[i])
            send_tone(TONE_W'(directed[i]));

        write_clock(CLK_HZ_MAX);
        send_tone(1);
        send_tone(3);
        send_tone(TONE_MAX);
        write_clock(1);
        send_tone(1);
        send_tone(2);
        write_clock(0);
        send_tone(7);

        run_phase(CLK_HZ_RESET,                            0,  0, 100, 1'b0);
        run_phase(CLK_HZ_MAX,                             56,  0, 100, 1'b0);
        run_phase(1,                                       0, 56,  40, 1'b0);
        run_phase(CLK_W'($urandom_range(CLK_HZ_MAX, 1)),  19, 19, 100, 1'b0);
        run_phase(48000000,                                0,  0, 100, 1'b1);
        run_phase(CLK_W'($urandom_range(2000000, 1000)),  56,  0, 100, 1'b0);
        run_phase(0,                                       0, 56,  20, 1'b0);
        run_phase(CLK_W'($urandom_range(CLK_HZ_MAX, 1)),  19, 19, 100, 1'b0);
        run_phase(CLK_HZ_RESET,                            0, 56,  90, 1'b0);

        wait_for_results();
        receiver_stall_pct <= 0;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.pending_settings.size() != 0)
            sb.report($sformatf("%0d expected results never arrived",
                                sb.pending_settings.size()));

        $display("Ran %0d tone requests across %0d clock settings, including zero and full scale.",
                 requests_sent, clock_writes);
        $display("Checked %0d results: %0d with usable settings, %0d flagged invalid.",
                 sb.results_checked, sb.valid_results, sb.results_checked - sb.valid_results);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #12000000;
        $display("Timeout with %0d results still expected", sb.pending_settings.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
